// ===== hdl/via_pkg.sv =====
package via_pkg;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_TICK    = 3'd2,
    OP_PRESS   = 3'd3,
    OP_RELEASE = 3'd4,
    OP_PS2     = 3'd5,
    OP_JOY     = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  localparam logic [3:0] REG_ORB   = 4'd0;
  localparam logic [3:0] REG_ORA   = 4'd1;
  localparam logic [3:0] REG_DDRB  = 4'd2;
  localparam logic [3:0] REG_DDRA  = 4'd3;
  localparam logic [3:0] REG_T1CL  = 4'd4;
  localparam logic [3:0] REG_T1CH  = 4'd5;
  localparam logic [3:0] REG_T1LL  = 4'd6;
  localparam logic [3:0] REG_T1LH  = 4'd7;
  localparam logic [3:0] REG_T2CL  = 4'd8;
  localparam logic [3:0] REG_T2CH  = 4'd9;
  localparam logic [3:0] REG_SR    = 4'd10;
  localparam logic [3:0] REG_ACR   = 4'd11;
  localparam logic [3:0] REG_PCR   = 4'd12;
  localparam logic [3:0] REG_IFR   = 4'd13;
  localparam logic [3:0] REG_IER   = 4'd14;

  localparam logic [7:0] FLAG_CA2 = 8'h01;
  localparam logic [7:0] FLAG_CA1 = 8'h02;
  localparam logic [7:0] FLAG_SR  = 8'h04;
  localparam logic [7:0] FLAG_CB2 = 8'h08;
  localparam logic [7:0] FLAG_CB1 = 8'h10;
  localparam logic [7:0] FLAG_T2  = 8'h20;
  localparam logic [7:0] FLAG_T1  = 8'h40;

  typedef struct packed {
    logic       hit;
    logic [2:0] row;
    logic [2:0] col;
  } key_hit_t;

  function automatic logic [7:0] key_at(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd0: v = 8'h60;  6'd1: v = 8'h31;  6'd2: v = 8'h32;  6'd3: v = 8'h33;
      6'd4: v = 8'h34;  6'd5: v = 8'h35;  6'd6: v = 8'h36;  6'd7: v = 8'h37;
      6'd8: v = 8'h38;  6'd9: v = 8'h39;  6'd10: v = 8'h30; 6'd11: v = 8'h2D;
      6'd12: v = 8'h3D; 6'd13: v = 8'h08; 6'd14: v = 8'h1B; 6'd15: v = 8'h09;
      6'd16: v = 8'h71; 6'd17: v = 8'h77; 6'd18: v = 8'h65; 6'd19: v = 8'h72;
      6'd20: v = 8'h74; 6'd21: v = 8'h79; 6'd22: v = 8'h75; 6'd23: v = 8'h69;
      6'd24: v = 8'h6F; 6'd25: v = 8'h70; 6'd26: v = 8'h5B; 6'd27: v = 8'h5D;
      6'd28: v = 8'h5C; 6'd31: v = 8'h61;
      6'd32: v = 8'h73; 6'd33: v = 8'h64; 6'd34: v = 8'h66; 6'd35: v = 8'h67;
      6'd36: v = 8'h68; 6'd37: v = 8'h6A; 6'd38: v = 8'h6B; 6'd39: v = 8'h6C;
      6'd40: v = 8'h3B; 6'd41: v = 8'h27; 6'd42: v = 8'h0D; 6'd43: v = 8'h7F;
      6'd45: v = 8'h7A; 6'd46: v = 8'h78; 6'd47: v = 8'h63;
      6'd48: v = 8'h76; 6'd49: v = 8'h62; 6'd50: v = 8'h6E; 6'd51: v = 8'h6D;
      6'd52: v = 8'h2C; 6'd53: v = 8'h2E; 6'd54: v = 8'h2F;
      6'd59: v = 8'h20;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic code_enables(input logic [2:0] c);
    return !(c == 3'd4 || c == 3'd5 || c == 3'd7);
  endfunction

endpackage

// ===== hdl/via_keyfind.sv =====
module via_keyfind import via_pkg::*; (
  input  logic [7:0] key_code_i,
  output key_hit_t   hit_o
);

  // Priority search, lowest table index wins.
  always_comb begin
    hit_o = '0;
    for (int i = 63; i >= 0; i--) begin
      if (key_at(6'(i)) == key_code_i) begin
        hit_o.hit = 1'b1;
        hit_o.row = 3'(i >> 3);
        hit_o.col = 3'(i);
      end
    end
  end

endmodule

// ===== hdl/via_6522_with_keyboard_ports_core.sv =====
// Channel | valid        | stall        | payload
// input   | in_valid_i   | in_stall_o   | op_i, reg_addr_i, write_data_i, key_code_i,
//         |              |              | joystick_buttons_i
// result  | out_valid_o  | out_stall_i  | read_data_o, irq_o
// Every request is applied in the cycle it is accepted; its result appears in
// the result register on the next cycle, one request per cycle sustained while the output is not stalled.
// The state update is one pass of logic from the register file into itself.
// Input stalls only while a result is held and the output is stalled.
// Reset is asynchronous, active low, and sets all control and state but the read data register to its reset value.
module via_6522_with_keyboard_ports_core import via_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] op_i,
  input  logic [3:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] key_code_i,
  input  logic [7:0] joystick_buttons_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       irq_o
);

  logic [7:0]  out_b_q, out_a_q, dir_b_q, dir_a_q;
  logic [15:0] t1_count_q, t1_latch_q, t2_count_q;
  logic [7:0]  t2_latch_low_q, shift_q, acr_q, pcr_q;
  logic [6:0]  ifr_q, ier_q;
  logic        t1_act_q, t2_act_q;
  logic [7:0]  rows_q [8];
  logic [7:0]  enc_byte_q, ps2_byte_q, joy_q;
  logic        enc_rdy_q, ps2_rdy_q, enc_on_q, ps2_on_q;

  logic [7:0]  out_b_d, out_a_d, dir_b_d, dir_a_d;
  logic [15:0] t1_count_d, t1_latch_d, t2_count_d;
  logic [7:0]  t2_latch_low_d, shift_d, acr_d, pcr_d;
  logic [6:0]  ifr_d, ier_d;
  logic        t1_act_d, t2_act_d;
  logic [7:0]  rows_d [8];
  logic [7:0]  enc_byte_d, ps2_byte_d, joy_d;
  logic        enc_rdy_d, ps2_rdy_d, enc_on_d, ps2_on_d;

  logic       rvalid_q;
  logic [7:0] rdata_q, rd;
  logic       irq_q;
  logic       accept;
  key_hit_t   hit;
  logic [7:0] ext_a, ext_b, port_a, port_b;
  logic [15:0] t1_dec, t2_dec;
  op_e         op;

  assign in_stall_o  = rvalid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = rvalid_q;
  assign read_data_o = rdata_q;
  assign irq_o       = irq_q;
  assign op          = op_e'(op_i);
  assign t1_dec      = t1_count_q - 16'd1;
  assign t2_dec      = t2_count_q - 16'd1;

  via_keyfind u_find (.key_code_i(key_code_i), .hit_o(hit));

  always_comb begin
    if (ps2_on_q && ps2_rdy_q) begin
      ext_a = ps2_byte_q;
    end else begin
      ext_a = ~joy_q;
      if (!enc_on_q) begin
        for (int r = 0; r < 8; r++) begin
          if ((rows_q[r] & ~out_b_q) != 8'd0) ext_a[r] = 1'b0;
        end
      end
    end
    if (enc_on_q && enc_rdy_q) ext_b = enc_byte_q;
    else if (!enc_on_q) ext_b = 8'hFF;
    else ext_b = ~joy_q;
    port_a = (dir_a_q & out_a_q) | (~dir_a_q & ext_a);
    port_b = (dir_b_q & out_b_q) | (~dir_b_q & ext_b);
  end

  always_comb begin
    out_b_d = out_b_q; out_a_d = out_a_q; dir_b_d = dir_b_q; dir_a_d = dir_a_q;
    t1_count_d = t1_count_q; t1_latch_d = t1_latch_q; t2_count_d = t2_count_q;
    t2_latch_low_d = t2_latch_low_q; shift_d = shift_q; acr_d = acr_q;
    pcr_d = pcr_q; ifr_d = ifr_q; ier_d = ier_q;
    t1_act_d = t1_act_q; t2_act_d = t2_act_q;
    rows_d = rows_q;
    enc_byte_d = enc_byte_q; ps2_byte_d = ps2_byte_q; joy_d = joy_q;
    enc_rdy_d = enc_rdy_q; ps2_rdy_d = ps2_rdy_q;
    enc_on_d = enc_on_q; ps2_on_d = ps2_on_q;
    rd = 8'd0;
    case (op)
      OP_READ: begin
        case (reg_addr_i)
          REG_ORB: begin
            ifr_d = ifr_q & ~7'(FLAG_CB1 | FLAG_CB2);
            rd = port_b; enc_rdy_d = 1'b0;
          end
          REG_ORA: begin
            ifr_d = ifr_q & ~7'(FLAG_CA1 | FLAG_CA2);
            rd = port_a; ps2_rdy_d = 1'b0;
          end
          REG_DDRB: rd = dir_b_q;
          REG_DDRA: rd = dir_a_q;
          REG_T1CL: begin ifr_d = ifr_q & ~7'(FLAG_T1); rd = t1_count_q[7:0]; end
          REG_T1CH: rd = t1_count_q[15:8];
          REG_T1LL: rd = t1_latch_q[7:0];
          REG_T1LH: rd = t1_latch_q[15:8];
          REG_T2CL: begin ifr_d = ifr_q & ~7'(FLAG_T2); rd = t2_count_q[7:0]; end
          REG_T2CH: rd = t2_count_q[15:8];
          REG_SR: begin ifr_d = ifr_q & ~7'(FLAG_SR); rd = shift_q; end
          REG_ACR: rd = acr_q;
          REG_PCR: rd = pcr_q;
          REG_IFR: rd = {(ifr_q & ier_q) != 7'd0, ifr_q};
          REG_IER: rd = {1'b1, ier_q};
          default: rd = port_a;
        endcase
      end
      OP_WRITE: begin
        case (reg_addr_i)
          REG_ORB: begin ifr_d = ifr_q & ~7'(FLAG_CB1 | FLAG_CB2); out_b_d = write_data_i; end
          REG_ORA: begin ifr_d = ifr_q & ~7'(FLAG_CA1 | FLAG_CA2); out_a_d = write_data_i; end
          REG_DDRB: dir_b_d = write_data_i;
          REG_DDRA: dir_a_d = write_data_i;
          REG_T1CL, REG_T1LL: t1_latch_d[7:0] = write_data_i;
          REG_T1CH: begin
            t1_latch_d[15:8] = write_data_i;
            t1_count_d = {write_data_i, t1_latch_q[7:0]};
            ifr_d = ifr_q & ~7'(FLAG_T1); t1_act_d = 1'b1;
          end
          REG_T1LH: begin
            t1_latch_d[15:8] = write_data_i; ifr_d = ifr_q & ~7'(FLAG_T1);
          end
          REG_T2CL: t2_latch_low_d = write_data_i;
          REG_T2CH: begin
            t2_count_d = {write_data_i, t2_latch_low_q};
            ifr_d = ifr_q & ~7'(FLAG_T2); t2_act_d = 1'b1;
          end
          REG_SR: begin shift_d = write_data_i; ifr_d = ifr_q & ~7'(FLAG_SR); end
          REG_ACR: acr_d = write_data_i;
          REG_PCR: begin
            pcr_d = write_data_i;
            ps2_on_d = code_enables(write_data_i[3:1]);
            enc_on_d = code_enables(write_data_i[7:5]);
          end
          REG_IFR: ifr_d = ifr_q & ~write_data_i[6:0];
          REG_IER: begin
            if (write_data_i[7]) ier_d = ier_q | write_data_i[6:0];
            else ier_d = ier_q & ~write_data_i[6:0];
          end
          default: out_a_d = write_data_i;
        endcase
      end
      OP_TICK: begin
        if (t1_act_q && t1_count_q != 16'd0) begin
          t1_count_d = t1_dec;
          if (t1_dec == 16'd0) begin
            ifr_d = ifr_d | 7'(FLAG_T1);
            if (acr_q[6]) t1_count_d = t1_latch_q;
            else t1_act_d = 1'b0;
            if (acr_q[7]) out_b_d = out_b_q ^ 8'h80;
          end
        end
        if (t2_act_q && t2_count_q != 16'd0) begin
          t2_count_d = t2_dec;
          if (t2_dec == 16'd0) begin
            ifr_d = ifr_d | 7'(FLAG_T2); t2_act_d = 1'b0;
          end
        end
      end
      OP_PRESS: begin
        if (hit.hit) begin
          rows_d[hit.row] = rows_q[hit.row] | (8'd1 << hit.col);
          if (enc_on_q) begin
            enc_byte_d = key_code_i; enc_rdy_d = 1'b1;
            ifr_d = ifr_q | 7'(FLAG_CB1);
          end
        end
      end
      OP_RELEASE: begin
        if (hit.hit) rows_d[hit.row] = rows_q[hit.row] & ~(8'd1 << hit.col);
      end
      OP_PS2: begin
        if (ps2_on_q) begin
          ps2_byte_d = key_code_i; ps2_rdy_d = 1'b1;
          ifr_d = ifr_q | 7'(FLAG_CA1);
        end
      end
      OP_JOY: joy_d = joystick_buttons_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_b_q <= '0; out_a_q <= '0; dir_b_q <= '0; dir_a_q <= '0;
      t1_count_q <= 16'hFFFF; t1_latch_q <= 16'hFFFF; t2_count_q <= 16'hFFFF;
      t2_latch_low_q <= 8'hFF; shift_q <= '0; acr_q <= '0; pcr_q <= '0;
      ifr_q <= '0; ier_q <= '0; t1_act_q <= 1'b0; t2_act_q <= 1'b0;
      for (int i = 0; i < 8; i++) rows_q[i] <= '0;
      enc_byte_q <= '0; ps2_byte_q <= '0; joy_q <= '0;
      enc_rdy_q <= 1'b0; ps2_rdy_q <= 1'b0; enc_on_q <= 1'b1; ps2_on_q <= 1'b1;
      rvalid_q <= 1'b0; irq_q <= 1'b0;
    end else begin
      if (accept) begin
        out_b_q <= out_b_d; out_a_q <= out_a_d; dir_b_q <= dir_b_d; dir_a_q <= dir_a_d;
        t1_count_q <= t1_count_d; t1_latch_q <= t1_latch_d; t2_count_q <= t2_count_d;
        t2_latch_low_q <= t2_latch_low_d; shift_q <= shift_d; acr_q <= acr_d;
        pcr_q <= pcr_d; ifr_q <= ifr_d; ier_q <= ier_d;
        t1_act_q <= t1_act_d; t2_act_q <= t2_act_d;
        rows_q <= rows_d;
        enc_byte_q <= enc_byte_d; ps2_byte_q <= ps2_byte_d; joy_q <= joy_d;
        enc_rdy_q <= enc_rdy_d; ps2_rdy_q <= ps2_rdy_d;
        enc_on_q <= enc_on_d; ps2_on_q <= ps2_on_d;
        irq_q <= (ifr_d & ier_d) != 7'd0;
        rvalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        rvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rdata_q <= rd;
  end

  a_irq_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (irq_q == ((ifr_q & ier_q) != 7'd0)))
    else $error("irq out of step with flags");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)))
    else $error("stalled result changed");
  a_t_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_TICK && t2_act_q && t2_count_q == 16'd1) |=> !t2_act_q)
    else $error("timer 2 did not stop");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import via_pkg::*;

  typedef struct packed {
    op_e        op;
    logic [3:0] addr;
    logic [7:0] wdata;
    logic [7:0] key;
    logic [7:0] joy;
  } via_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } via_rsp_t;

  localparam int STALL_LIMIT = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] op_i = '0;
  logic [3:0] reg_addr_i = '0;
  logic [7:0] write_data_i = '0;
  logic [7:0] key_code_i = '0;
  logic [7:0] joystick_buttons_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;
  logic       irq_o;

  via_6522_with_keyboard_ports_core DUT (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the register file and key matrix.
  logic [7:0]  m_orb, m_ora, m_ddrb, m_ddra;
  logic [15:0] m_t1c, m_t1l, m_t2c;
  logic [7:0]  m_t2ll, m_sr, m_acr, m_pcr, m_ifr;
  logic [6:0]  m_ier;
  logic        m_t1on, m_t2on;
  logic [7:0]  m_rows [8];
  logic [7:0]  m_enc, m_ps2, m_joy;
  logic        m_enc_rdy, m_ps2_rdy, m_enc_on, m_ps2_on;

  via_req_t pending_reqs[$];
  via_rsp_t expected_rsps[$];
  int  errors = 0;
  int  sent = 0;
  bit  stim_done = 0;
  bit  hold_off = 0;
  int  hold_cycles = 0;
  int  idle_cycles = 0;

  const logic [7:0] KEYMAP [64] = '{
    8'h60, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h1B, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h5C, 8'h00, 8'h00, 8'h61,
    8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C,
    8'h3B, 8'h27, 8'h0D, 8'h7F, 8'h00, 8'h7A, 8'h78, 8'h63,
    8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00};

  function automatic bit irq_pending();
    return (m_ifr[6:0] & m_ier) != 7'd0;
  endfunction

  function automatic void refresh_any();
    m_ifr[7] = irq_pending();
  endfunction

  function automatic void drop_flags(logic [7:0] f);
    m_ifr = m_ifr & ~f;
    refresh_any();
  endfunction

  function automatic void raise_flags(logic [7:0] f);
    m_ifr = m_ifr | f;
    refresh_any();
  endfunction

  function automatic bit source_on(logic [2:0] c);
    return !(c == 3'd4 || c == 3'd5 || c == 3'd7);
  endfunction

  function automatic int lookup_key(logic [7:0] k);
    for (int i = 0; i < 64; i++)
      if (KEYMAP[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [7:0] port_a_in();
    logic [7:0] ext;
    if (m_ps2_on && m_ps2_rdy) begin
      ext = m_ps2;
    end else begin
      ext = ~m_joy;
      if (!m_enc_on)
        for (int r = 0; r < 8; r++)
          if ((m_rows[r] & ~m_orb) != 8'd0) ext[r] = 1'b0;
    end
    return (m_ddra & m_ora) | (~m_ddra & ext);
  endfunction

  function automatic logic [7:0] port_b_in();
    logic [7:0] ext;
    if (m_enc_on && m_enc_rdy) ext = m_enc;
    else if (!m_enc_on) ext = 8'hFF;
    else ext = ~m_joy;
    return (m_ddrb & m_orb) | (~m_ddrb & ext);
  endfunction

  function automatic void reset_shadow();
    m_orb = 0; m_ora = 0; m_ddrb = 0; m_ddra = 0;
    m_t1c = 16'hFFFF; m_t1l = 16'hFFFF; m_t2c = 16'hFFFF; m_t2ll = 8'hFF;
    m_sr = 0; m_acr = 0; m_pcr = 0; m_ifr = 0; m_ier = 0;
    m_t1on = 0; m_t2on = 0;
    for (int r = 0; r < 8; r++) m_rows[r] = 0;
    m_enc = 0; m_ps2 = 0; m_joy = 0;
    m_enc_rdy = 0; m_ps2_rdy = 0; m_enc_on = 1; m_ps2_on = 1;
  endfunction

  function automatic logic [7:0] read_register(logic [3:0] a);
    logic [7:0] v;
    case (a)
      REG_ORB: begin
        drop_flags(FLAG_CB1 | FLAG_CB2); v = port_b_in(); m_enc_rdy = 0;
      end
      REG_ORA: begin
        drop_flags(FLAG_CA1 | FLAG_CA2); v = port_a_in(); m_ps2_rdy = 0;
      end
      REG_DDRB: v = m_ddrb;
      REG_DDRA: v = m_ddra;
      REG_T1CL: begin
        drop_flags(FLAG_T1); v = m_t1c[7:0];
      end
      REG_T1CH: v = m_t1c[15:8];
      REG_T1LL: v = m_t1l[7:0];
      REG_T1LH: v = m_t1l[15:8];
      REG_T2CL: begin
        drop_flags(FLAG_T2); v = m_t2c[7:0];
      end
      REG_T2CH: v = m_t2c[15:8];
      REG_SR: begin
        drop_flags(FLAG_SR); v = m_sr;
      end
      REG_ACR: v = m_acr;
      REG_PCR: v = m_pcr;
      REG_IFR: v = {irq_pending(), m_ifr[6:0]};
      REG_IER: v = {1'b1, m_ier};
      default: v = port_a_in();
    endcase
    return v;
  endfunction

  function automatic void write_register(logic [3:0] a, logic [7:0] d);
    case (a)
      REG_ORB: begin
        drop_flags(FLAG_CB1 | FLAG_CB2); m_orb = d;
      end
      REG_ORA: begin
        drop_flags(FLAG_CA1 | FLAG_CA2); m_ora = d;
      end
      REG_DDRB: m_ddrb = d;
      REG_DDRA: m_ddra = d;
      REG_T1CL, REG_T1LL: m_t1l[7:0] = d;
      REG_T1CH: begin
        m_t1l[15:8] = d; m_t1c = m_t1l; drop_flags(FLAG_T1); m_t1on = 1;
      end
      REG_T1LH: begin
        m_t1l[15:8] = d; drop_flags(FLAG_T1);
      end
      REG_T2CL: m_t2ll = d;
      REG_T2CH: begin
        m_t2c = {d, m_t2ll}; drop_flags(FLAG_T2); m_t2on = 1;
      end
      REG_SR: begin
        m_sr = d; drop_flags(FLAG_SR);
      end
      REG_ACR: m_acr = d;
      REG_PCR: begin
        m_pcr = d; m_ps2_on = source_on(d[3:1]); m_enc_on = source_on(d[7:5]);
      end
      REG_IFR: drop_flags({1'b0, d[6:0]});
      REG_IER: begin
        if (d[7]) m_ier = m_ier | d[6:0];
        else m_ier = m_ier & ~d[6:0];
        refresh_any();
      end
      default: m_ora = d;
    endcase
  endfunction

  function automatic void timer_tick();
    if (m_t1on && m_t1c != 16'd0) begin
      m_t1c = m_t1c - 16'd1;
      if (m_t1c == 16'd0) begin
        raise_flags(FLAG_T1);
        if (m_acr[6]) m_t1c = m_t1l;
        else m_t1on = 0;
        if (m_acr[7]) m_orb[7] = ~m_orb[7];
      end
    end
    if (m_t2on && m_t2c != 16'd0) begin
      m_t2c = m_t2c - 16'd1;
      if (m_t2c == 16'd0) begin
        raise_flags(FLAG_T2); m_t2on = 0;
      end
    end
  endfunction

  function automatic via_rsp_t apply_request(via_req_t q);
    via_rsp_t rsp;
    int idx;
    rsp.rdata = 0;
    case (q.op)
      OP_READ: rsp.rdata = read_register(q.addr);
      OP_WRITE: write_register(q.addr, q.wdata);
      OP_TICK: timer_tick();
      OP_PRESS: begin
        idx = lookup_key(q.key);
        if (idx >= 0) begin
          m_rows[idx / 8][idx % 8] = 1'b1;
          if (m_enc_on) begin
            m_enc = q.key; m_enc_rdy = 1; raise_flags(FLAG_CB1);
          end
        end
      end
      OP_RELEASE: begin
        idx = lookup_key(q.key);
        if (idx >= 0) m_rows[idx / 8][idx % 8] = 1'b0;
      end
      OP_PS2: begin
        if (m_ps2_on) begin
          m_ps2 = q.key; m_ps2_rdy = 1; raise_flags(FLAG_CA1);
        end
      end
      OP_JOY: m_joy = q.joy;
      default: ;
    endcase
    rsp.irq = irq_pending();
    return rsp;
  endfunction

  function automatic void push_req(op_e op, logic [3:0] a, logic [7:0] w,
                                   logic [7:0] k, logic [7:0] j);
    via_req_t q;
    q.op = op; q.addr = a; q.wdata = w; q.key = k; q.joy = j;
    pending_reqs.push_back(q);
  endfunction

  function automatic void push_random();
    int pick;
    int sel;
    logic [7:0] k;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 63);
    k = ($urandom_range(0, 3) == 0) ? 8'($urandom) : KEYMAP[sel];
    if (pick < 25) begin
      push_req(OP_READ, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 45) begin
      // Timer writes favor short counts so the timers actually expire.
      sel = $urandom_range(0, 15);
      if ((sel == REG_T1CH || sel == REG_T2CH || sel == REG_T1LH)
          && $urandom_range(0, 3) != 0)
        push_req(OP_WRITE, 4'(sel), 8'h00, 8'($urandom), 8'($urandom));
      else if ((sel == REG_T1CL || sel == REG_T2CL || sel == REG_T1LL)
               && $urandom_range(0, 1) == 1)
        push_req(OP_WRITE, 4'(sel), 8'($urandom_range(0, 6)), 8'($urandom),
                 8'($urandom));
      else
        push_req(OP_WRITE, 4'(sel), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 70) begin
      push_req(OP_TICK, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 80) begin
      push_req(OP_PRESS, 4'($urandom), 8'($urandom), k, 8'($urandom));
    end else if (pick < 87) begin
      push_req(OP_RELEASE, 4'($urandom), 8'($urandom), k, 8'($urandom));
    end else if (pick < 93) begin
      push_req(OP_PS2, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 98) begin
      push_req(OP_JOY, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      push_req(OP_NONE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued requests, with random gaps between them.
  int gap_left = 0;
  always @(posedge clk_i) begin
    via_req_t q;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
        sent <= sent + 1;
        gap_left = gap_length();
      end
      if (in_valid_i && in_stall_o) begin
        // Hold the stalled request steady.
      end else if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else begin
        q = pending_reqs[0];
        in_valid_i <= 1'b1;
        op_i <= q.op;
        reg_addr_i <= q.addr;
        write_data_i <= q.wdata;
        key_code_i <= q.key;
        joystick_buttons_i <= q.joy;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    via_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result read_data=%h irq=%b", read_data_o, irq_o);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (read_data_o !== want.rdata) begin
            $error("read_data expected %h actual %h", want.rdata, read_data_o);
            errors++;
          end
          if (irq_o !== want.irq) begin
            $error("irq expected %b actual %b", want.irq, irq_o);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else if (hold_off) begin
        hold_cycles <= 60;
        out_stall_i <= 1'b1;
      end else if (stim_done || $urandom_range(0, 9) < 6) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 19) == 0) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int target;
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests: extremes, every operation, special cases.
    push_req(OP_READ, REG_T1CL, 8'h00, 8'h00, 8'h00);
    push_req(OP_WRITE, REG_IER, 8'hFF, 8'hFF, 8'hFF);
    push_req(OP_WRITE, REG_T1CL, 8'h02, 8'h00, 8'h00);
    push_req(OP_WRITE, REG_ACR, 8'hC0, 8'h00, 8'h00);
    push_req(OP_WRITE, REG_T1CH, 8'h00, 8'h00, 8'h00);
    push_req(OP_TICK, 4'hF, 8'hFF, 8'hFF, 8'hFF);
    push_req(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00);
    push_req(OP_READ, REG_IFR, 8'h00, 8'h00, 8'h00);
    // Free run with a zero latch stays at zero.
    push_req(OP_WRITE, REG_T1CL, 8'h00, 8'h00, 8'h00);
    push_req(OP_WRITE, REG_T1CH, 8'h00, 8'h00, 8'h00);
    push_req(OP_TICK, 4'h0, 8'h00, 8'h00, 8'h00);
    push_req(OP_WRITE, REG_IFR, 8'hFF, 8'h00, 8'h00);
    push_req(OP_PRESS, 4'h0, 8'h00, 8'h00, 8'h00);
    push_req(OP_PRESS, 4'h0, 8'h00, 8'h1B, 8'h00);
    push_req(OP_PRESS, 4'h0, 8'h00, 8'hFF, 8'h00);
    push_req(OP_READ, REG_ORB, 8'h00, 8'h00, 8'h00);
    push_req(OP_PS2, 4'h0, 8'h00, 8'h0D, 8'h00);
    push_req(OP_READ, 4'hF, 8'h00, 8'h00, 8'h00);
    push_req(OP_READ, REG_ORA, 8'h00, 8'h00, 8'h00);
    push_req(OP_JOY, 4'h0, 8'h00, 8'h00, 8'hFF);
    push_req(OP_WRITE, REG_PCR, 8'hEE, 8'h00, 8'h00);
    push_req(OP_WRITE, REG_ORB, 8'h00, 8'h00, 8'h00);
    push_req(OP_READ, REG_ORA, 8'h00, 8'h00, 8'h00);
    push_req(OP_RELEASE, 4'h0, 8'h00, 8'h7F, 8'h00);
    push_req(OP_NONE, 4'hF, 8'hFF, 8'hFF, 8'hFF);

    // Receiver holds off while the sender keeps offering.
    for (int i = 0; i < 40; i++) push_random();
    wait (pending_reqs.size() < 30);
    hold_off = 1;
    // The monitor takes the hold over by loading its own counter.
    wait (hold_cycles > 0);
    hold_off = 0;
    wait (pending_reqs.size() == 0 && hold_cycles == 0);

    // Sender pauses until every expected result has come.
    wait (expected_rsps.size() == 0);
    repeat (3) @(posedge clk_i);

    target = 1100;
    while (target > 0) begin
      for (int i = 0; i < 100 && target > 0; i++, target--) push_random();
      wait (pending_reqs.size() < 20);
    end
    wait (pending_reqs.size() == 0 && !in_valid_i);
    stim_done = 1;
    wait (expected_rsps.size() == 0);
    repeat (5) @(posedge clk_i);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/via_pkg.sv
hdl/via_keyfind.sv
hdl/via_6522_with_keyboard_ports_core.sv
verif/testbench.sv
